/* hdl/csow_pkg.sv */
// Shared types and constants for the counting semaphore unit.
// Used by csow_scan and counting_semaphore_oldest_waiter; depends on nothing.
`default_nettype none

package csow_pkg;

	localparam int CountW = 16;
	localparam int AgeW   = 16;
	localparam int SemW   = 3;
	localparam int ThrW   = 3;
	localparam int CfgW   = 4;

	localparam logic [CountW-1:0] CountMax = 16'h7FFF;
	localparam logic [CountW-1:0] CountMin = 16'h8000;
	localparam logic [AgeW-1:0]   AgeMax   = 16'hFFFF;
	localparam logic [CfgW-1:0]   ActiveThreadsReset = 4'd8;

	typedef enum logic [1:0] {
		MODE_INIT   = 2'd0,
		MODE_WAIT   = 2'd1,
		MODE_SIGNAL = 2'd2,
		MODE_TICK   = 2'd3
	} mode_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EXEC,
		ST_SCAN,
		ST_WAKE,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic            start;
		logic [SemW-1:0] sem;
	} scan_ctrl_t;

	typedef struct packed {
		logic busy;
		logic found;
	} scan_status_t;

endpackage

`default_nettype wire

/* hdl/counting_semaphore_oldest_waiter.sv */
// An accepted init, wait or tick passes through execute and done into the output register;
// a signal that must search also passes through scan and wake, the scan covering N entries,
// N = min(active_threads, MAX_THREADS). A new item is taken only once the last has left done.
// Reset (arst_n low, asynchronous) clears all counts, the thread table, the
// sequencer and the output valid flag, and sets active_threads to 8.
// Depends on csow_pkg and csow_scan.
`default_nettype none

module counting_semaphore_oldest_waiter #(
	parameter int MAX_THREADS    = 8,
	parameter int NUM_SEMAPHORES = 8
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	// Configuration: one register, active_threads.
	input  wire logic                              cfg_write_en,
	input  wire logic [csow_pkg::CfgW-1:0]         cfg_write_data,
	// Input channel.
	input  wire logic                              in_valid,
	output logic                                   in_stall,
	input  wire logic [1:0]                        mode,
	input  wire logic [csow_pkg::SemW-1:0]         sem_index,
	input  wire logic [csow_pkg::ThrW-1:0]         thread_index,
	input  wire logic signed [csow_pkg::CountW-1:0] init_value,
	// Output channel.
	output logic                                   out_valid,
	input  wire logic                              out_stall,
	output logic                                   caller_blocks,
	output logic                                   woken_valid,
	output logic [csow_pkg::ThrW-1:0]              woken_thread,
	output logic signed [csow_pkg::CountW-1:0]     count_after
);

	localparam int TW = $clog2(MAX_THREADS);
	localparam int LW = $clog2(MAX_THREADS + 1);
	localparam int SW = (NUM_SEMAPHORES > 1) ? $clog2(NUM_SEMAPHORES) : 1;

	// Configuration register.
	logic [csow_pkg::CfgW-1:0] active_threads_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_threads_q <= csow_pkg::ActiveThreadsReset;
		end else if (cfg_write_en) begin
			active_threads_q <= cfg_write_data;
		end
	end

	// The scan covers the configured number of entries, clipped to the table size.
	logic [LW-1:0] scan_len;

	always_comb begin
		if (32'(active_threads_q) > MAX_THREADS) begin
			scan_len = LW'(MAX_THREADS);
		end else begin
			scan_len = LW'(active_threads_q);
		end
	end

	// Captured item.
	csow_pkg::mode_t               mode_q;
	logic [csow_pkg::SemW-1:0]     sem_q;
	logic [csow_pkg::ThrW-1:0]     thr_q;
	logic [csow_pkg::CountW-1:0]   initv_q;

	// Result of the item being worked on.
	logic [csow_pkg::CountW-1:0]   cnt_q;
	logic                          blocks_q;
	logic                          wvalid_q;
	logic [TW-1:0]                 wthread_q;

	// Semaphore counts and thread table, all cleared by reset.
	logic [csow_pkg::CountW-1:0]   sem_count_q [NUM_SEMAPHORES];
	logic                          waiting_q   [MAX_THREADS];
	logic [csow_pkg::SemW-1:0]     waits_on_q  [MAX_THREADS];
	logic [csow_pkg::AgeW-1:0]     age_q       [MAX_THREADS];

	// Sequencer.
	csow_pkg::state_t              state_q;
	csow_pkg::state_t              state_d;
	csow_pkg::scan_ctrl_t          scan_ctrl;
	csow_pkg::scan_status_t        scan_status;
	logic [TW-1:0]                 scan_idx;
	logic [TW-1:0]                 scan_best;

	logic                          accept;
	logic                          exec_en;
	logic                          wake_en;
	logic                          done_st;
	logic                          out_load;
	logic                          out_valid_q;

	assign accept   = in_valid && !in_stall;
	assign out_load = done_st && (!out_valid_q || !out_stall);

	// Execute stage: one read of the addressed count, one saturating increment or decrement.
	logic                          sem_ok;
	logic                          thr_ok;
	logic [SW-1:0]                 sem_addr;
	logic [TW-1:0]                 thr_addr;
	logic [csow_pkg::CountW-1:0]   cnt_rd;
	logic [csow_pkg::CountW-1:0]   cnt_new;
	logic                          blocks_new;
	logic                          need_scan;

	assign sem_ok   = (32'(sem_q) < NUM_SEMAPHORES);
	assign thr_ok   = (32'(thr_q) < MAX_THREADS);
	assign sem_addr = SW'(sem_q);
	assign thr_addr = TW'(thr_q);
	assign cnt_rd   = sem_ok ? sem_count_q[sem_addr] : '0;

	always_comb begin
		cnt_new    = cnt_rd;
		blocks_new = 1'b0;
		need_scan  = 1'b0;
		unique case (mode_q)
			csow_pkg::MODE_INIT: begin
				if (sem_ok) begin
					cnt_new = initv_q;
				end
			end
			csow_pkg::MODE_WAIT: begin
				if (sem_ok) begin
					if (cnt_rd != csow_pkg::CountMin) begin
						cnt_new = cnt_rd - csow_pkg::CountW'(1);
					end
					blocks_new = cnt_new[csow_pkg::CountW-1];
				end
			end
			csow_pkg::MODE_SIGNAL: begin
				if (sem_ok) begin
					if (cnt_rd != csow_pkg::CountMax) begin
						cnt_new = cnt_rd + csow_pkg::CountW'(1);
					end
					need_scan = cnt_new[csow_pkg::CountW-1] || (cnt_new == '0);
				end
			end
			csow_pkg::MODE_TICK: begin
				cnt_new = cnt_rd;
			end
			default: begin
				cnt_new = cnt_rd;
			end
		endcase
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			csow_pkg::ST_IDLE: begin
				if (in_valid) begin
					state_d = csow_pkg::ST_EXEC;
				end
			end
			csow_pkg::ST_EXEC: begin
				state_d = need_scan ? csow_pkg::ST_SCAN : csow_pkg::ST_DONE;
			end
			csow_pkg::ST_SCAN: begin
				if (!scan_status.busy) begin
					state_d = csow_pkg::ST_WAKE;
				end
			end
			csow_pkg::ST_WAKE: begin
				state_d = csow_pkg::ST_DONE;
			end
			csow_pkg::ST_DONE: begin
				if (!out_valid_q || !out_stall) begin
					state_d = csow_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = csow_pkg::ST_IDLE;
			end
		endcase
	end

	// Sequencer outputs.
	always_comb begin
		in_stall        = 1'b1;
		exec_en         = 1'b0;
		wake_en         = 1'b0;
		done_st         = 1'b0;
		scan_ctrl.start = 1'b0;
		scan_ctrl.sem   = sem_q;
		unique case (state_q)
			csow_pkg::ST_IDLE: begin
				in_stall = 1'b0;
			end
			csow_pkg::ST_EXEC: begin
				exec_en         = 1'b1;
				scan_ctrl.start = need_scan;
			end
			csow_pkg::ST_SCAN: begin
				in_stall = 1'b1;
			end
			csow_pkg::ST_WAKE: begin
				wake_en = 1'b1;
			end
			csow_pkg::ST_DONE: begin
				done_st = 1'b1;
			end
			default: begin
				in_stall = 1'b1;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= csow_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Capture of the accepted transfer; payload registers need no reset.
	always_ff @(posedge clk) begin
		if (accept) begin
			mode_q  <= csow_pkg::mode_t'(mode);
			sem_q   <= sem_index;
			thr_q   <= thread_index;
			initv_q <= init_value;
		end
	end

	// Working result. wvalid_q is cleared at execute and set only by a successful wake.
	always_ff @(posedge clk) begin
		if (exec_en) begin
			cnt_q     <= cnt_new;
			blocks_q  <= blocks_new;
			wvalid_q  <= 1'b0;
			wthread_q <= '0;
		end else if (wake_en && scan_status.found) begin
			wvalid_q  <= 1'b1;
			wthread_q <= scan_best;
		end
	end

	// Semaphore counts: written once per init, wait or signal on a valid index.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int s = 0; s < NUM_SEMAPHORES; s++) begin
				sem_count_q[s] <= '0;
			end
		end else if (exec_en && sem_ok && (mode_q != csow_pkg::MODE_TICK)) begin
			sem_count_q[sem_addr] <= cnt_new;
		end
	end

	// Thread table. A tick ages every waiting entry at once; a blocking wait
	// claims one entry; a wake frees the chosen one.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int t = 0; t < MAX_THREADS; t++) begin
				waiting_q[t]  <= 1'b0;
				waits_on_q[t] <= '0;
				age_q[t]      <= '0;
			end
		end else if (exec_en) begin
			if (mode_q == csow_pkg::MODE_TICK) begin
				for (int t = 0; t < MAX_THREADS; t++) begin
					if (waiting_q[t] && (age_q[t] != csow_pkg::AgeMax)) begin
						age_q[t] <= age_q[t] + csow_pkg::AgeW'(1);
					end
				end
			end else if (blocks_new && thr_ok) begin
				waiting_q[thr_addr]  <= 1'b1;
				waits_on_q[thr_addr] <= sem_q;
				age_q[thr_addr]      <= '0;
			end
		end else if (wake_en && scan_status.found) begin
			waiting_q[scan_best] <= 1'b0;
			age_q[scan_best]     <= '0;
		end
	end

	// The search unit walks the table one entry per cycle.
	csow_scan #(
		.MAX_THREADS (MAX_THREADS)
	) u_scan (
		.clk           (clk),
		.arst_n        (arst_n),
		.ctrl          (scan_ctrl),
		.len           (scan_len),
		.entry_waiting (waiting_q[scan_idx]),
		.entry_sem     (waits_on_q[scan_idx]),
		.entry_age     (age_q[scan_idx]),
		.idx           (scan_idx),
		.best          (scan_best),
		.status        (scan_status)
	);

	// Output register: holds a finished result until the downstream transfer,
	// while the next item is already being accepted and worked on.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			caller_blocks <= blocks_q;
			woken_valid   <= wvalid_q;
			woken_thread  <= csow_pkg::ThrW'(wthread_q);
			count_after   <= cnt_q;
		end
	end

	assign out_valid = out_valid_q;

endmodule

`default_nettype wire

/* hdl/csow_scan.sv */
// Iterative waiter search: one thread table entry per cycle through one comparator.
// Depends on csow_pkg.
`default_nettype none

module csow_scan #(
	parameter int MAX_THREADS = 8,
	localparam int TW = $clog2(MAX_THREADS),
	localparam int LW = $clog2(MAX_THREADS + 1)
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire csow_pkg::scan_ctrl_t              ctrl,
	input  wire logic [LW-1:0]                     len,
	input  wire logic                              entry_waiting,
	input  wire logic [csow_pkg::SemW-1:0]         entry_sem,
	input  wire logic [csow_pkg::AgeW-1:0]         entry_age,
	output logic [TW-1:0]                          idx,
	output logic [TW-1:0]                          best,
	output csow_pkg::scan_status_t                 status
);

	logic                          busy_q;
	logic                          found_q;
	logic [TW-1:0]                 idx_q;
	logic [TW-1:0]                 best_q;
	logic [LW-1:0]                 len_q;
	logic [csow_pkg::SemW-1:0]     sem_q;
	logic [csow_pkg::AgeW-1:0]     best_age_q;
	logic                          match;
	logic                          last;

	// Greater-or-equal lets a later entry of equal age take over, so ties go high.
	assign match = entry_waiting && (entry_sem == sem_q) && (entry_age >= best_age_q);
	assign last  = ((LW'(idx_q) + LW'(1)) == len_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			found_q <= 1'b0;
			idx_q   <= '0;
		end else if (ctrl.start) begin
			busy_q  <= (len != '0);
			found_q <= 1'b0;
			idx_q   <= '0;
		end else if (busy_q) begin
			if (match) begin
				found_q <= 1'b1;
			end
			if (last) begin
				busy_q <= 1'b0;
			end else begin
				idx_q <= idx_q + TW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.start) begin
			best_age_q <= '0;
			best_q     <= '0;
			sem_q      <= ctrl.sem;
			len_q      <= len;
		end else if (busy_q && match) begin
			best_age_q <= entry_age;
			best_q     <= idx_q;
		end
	end

	assign idx          = idx_q;
	assign best         = best_q;
	assign status.busy  = busy_q;
	assign status.found = found_q;

endmodule

`default_nettype wire
